@@ hdl/fqfa_pkg.sv @@
// Shared types and constants for the FASTQ/FASTA record parser.
// Transaction payload structs, parser state struct, character and tag codes.
// No dependencies.
`timescale 1ns / 1ps

package fqfa_pkg;

  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  localparam logic MODE_FASTQ = 1'b0;
  localparam logic MODE_FASTA = 1'b1;

  // Field tags, also the FASTQ parse states
  localparam logic [1:0] TAG_ID1  = 2'd0;
  localparam logic [1:0] TAG_SEQ  = 2'd1;
  localparam logic [1:0] TAG_ID2  = 2'd2;
  localparam logic [1:0] TAG_QUAL = 2'd3;

  // FASTA parse states; the fourth code behaves as sequence
  localparam logic [1:0] FA_INIT   = 2'd0;
  localparam logic [1:0] FA_HEADER = 2'd1;
  localparam logic [1:0] FA_SEQ    = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] field_tag;
    logic       has_byte;
    logic       record_last;
  } out_t;

  typedef struct packed {
    logic [1:0] parse_state;
    logic       at_line_start;
    logic       header_nonempty;
  } parse_t;

  localparam parse_t PARSE_RESET = '{parse_state: 2'd0, at_line_start: 1'b1,
                                     header_nonempty: 1'b0};

endpackage

@@ hdl/fqfa_step.sv @@
// Combinational next-state and result logic for one input byte or end of stream.
// Depends on fqfa_pkg.
`timescale 1ns / 1ps

module fqfa_step (
  input  logic           format_mode,
  input  fqfa_pkg::parse_t cur,
  input  fqfa_pkg::in_t  item,
  output fqfa_pkg::parse_t nxt,
  output logic           res_valid,
  output fqfa_pkg::out_t res
);
  import fqfa_pkg::*;

  logic [7:0] b;
  logic       fa_seq;

  assign b      = item.data_byte;
  assign fa_seq = cur.parse_state[1];

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '{out_byte: 8'd0, field_tag: TAG_SEQ, has_byte: 1'b0, record_last: 1'b1};
    if (item.cmd == CMD_EOS) begin
      nxt       = PARSE_RESET;
      res_valid = (format_mode == MODE_FASTA) && cur.header_nonempty;
    end else if (format_mode == MODE_FASTQ) begin
      if (cur.at_line_start && ((cur.parse_state == TAG_ID1 && b == CH_AT) ||
                                (cur.parse_state == TAG_ID2 && b == CH_PLUS))) begin
        // drop the line marker
        nxt.at_line_start = 1'b0;
      end else if (b == CH_NL) begin
        nxt.at_line_start = 1'b1;
        nxt.parse_state   = cur.parse_state + 2'd1;
        if (cur.parse_state == TAG_QUAL) begin
          res_valid       = 1'b1;
          res.field_tag   = TAG_QUAL;
        end
      end else begin
        nxt.at_line_start = 1'b0;
        res_valid         = 1'b1;
        res               = '{out_byte: b, field_tag: cur.parse_state, has_byte: 1'b1,
                              record_last: 1'b0};
      end
    end else begin
      if (cur.at_line_start && b == CH_GT) begin
        nxt.parse_state     = FA_HEADER;
        nxt.at_line_start   = 1'b0;
        nxt.header_nonempty = 1'b0;
        res_valid           = cur.header_nonempty;
      end else if (b == CH_NL) begin
        nxt.at_line_start = 1'b1;
        if (cur.parse_state == FA_HEADER) begin
          nxt.parse_state = FA_SEQ;
        end
      end else begin
        nxt.at_line_start = 1'b0;
        if (cur.parse_state == FA_HEADER) begin
          nxt.header_nonempty = 1'b1;
          res_valid           = 1'b1;
          res = '{out_byte: b, field_tag: TAG_ID1, has_byte: 1'b1, record_last: 1'b0};
        end else if (fa_seq && b != CH_SP) begin
          res_valid = 1'b1;
          res = '{out_byte: b, field_tag: TAG_SEQ, has_byte: 1'b1, record_last: 1'b0};
        end
      end
    end
  end

endmodule

@@ hdl/fqfa_skid.sv @@
// Two-entry output buffer: result register plus skid register.
// Stall toward the parser is registered. Depends on fqfa_pkg.
`timescale 1ns / 1ps

module fqfa_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fqfa_pkg::out_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output fqfa_pkg::out_t out_data
);
  import fqfa_pkg::*;

  logic skid_valid;
  out_t skid_data;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

@@ hdl/fastq_fasta_record_parser_unit.sv @@
// Top level of the FASTQ/FASTA record parser.
// Depends on fqfa_pkg, fqfa_step and fqfa_skid.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one transaction per
//   byte of the file, or an end-of-stream command. Output channel
//   (out_valid / out_stall / out_data) carries zero or one transaction per
//   input: a field byte tagged id1, sequence, id2 or quality, or a marker with
//   record_last set that closes a record.
//   cfg_write_enable / cfg_write_data set format_mode (0 FASTQ, 1 FASTA); write
//   it only while the block is idle.
// Timing:
//   One input transaction per cycle sustained while the skid has room. A result is
//   registered into the output or skid register; the parser state update is a
//   single short step of logic between the input port and those registers.
// Reset:
//   rst (synchronous) clears format_mode to FASTQ, puts the parser at line start
//   of the first field and empties the output buffer.
// Stall:
//   When the receiver stalls, the held result stays on out_data and one more
//   result goes into a skid register; in_stall rises only once the skid is full.

module fastq_fasta_record_parser_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write_enable,
  input  logic           cfg_write_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  fqfa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output fqfa_pkg::out_t out_data
);
  import fqfa_pkg::*;

  logic   format_mode;
  parse_t parse;
  parse_t parse_next;
  logic   res_valid;
  out_t   res;
  logic   accept;
  logic   full;

  // accept whenever the skid register has room
  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= MODE_FASTQ;
    end else if (cfg_write_enable) begin
      format_mode <= cfg_write_data;
    end
  end

  fqfa_step u_step (
    .format_mode (format_mode),
    .cur         (parse),
    .item        (in_data),
    .nxt         (parse_next),
    .res_valid   (res_valid),
    .res         (res)
  );

  // advance parser state on every accepted transaction, result or not
  always_ff @(posedge clk) begin
    if (rst) begin
      parse <= PARSE_RESET;
    end else if (accept) begin
      parse <= parse_next;
    end
  end

  fqfa_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
